// ===== design/lru_lfu_lookup_cache_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the lookup cache
// Concurrent assertion wrappers that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef LRU_LFU_LOOKUP_CACHE_MACROS_SVH
`define LRU_LFU_LOOKUP_CACHE_MACROS_SVH

`ifndef SYNTHESIS
`define LLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define LLC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define LLC_ASSERT(lbl, prop, msg)
`define LLC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== design/llc_pkg.sv =====
// ----------------------------------------------------------------------------
// Lookup cache package
// Field widths, codes and sequencer states shared by the cache files.
// ----------------------------------------------------------------------------
package llc_pkg;

  localparam int KEY_W  = 16;
  localparam int VAL_W  = 32;
  localparam int USES_W = 16;

  localparam logic [USES_W-1:0] USES_MAX = {USES_W{1'b1}};

  typedef enum logic {
    ACT_LOOKUP = 1'b0,
    ACT_INSERT = 1'b1
  } action_e;

  typedef enum logic {
    MODE_LRU = 1'b0,
    MODE_LFU = 1'b1
  } mode_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_LRU_UPD,
    S_USE_WR,
    S_EV_SCAN,
    S_INS_UPD,
    S_COPY_RD,
    S_COPY_WR,
    S_NEW_WR,
    S_RESP
  } state_e;

endpackage

// ===== design/llc_req_if.sv =====
// ----------------------------------------------------------------------------
// Lookup cache request channel
// Carries one lookup or insert request with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface llc_req_if import llc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic [KEY_W-1:0]        key;
  logic signed [VAL_W-1:0] value_in;

  modport source (output valid, output action, output key, output value_in, input ready);
  modport sink   (input valid, input action, input key, input value_in, output ready);
endinterface

// ===== design/llc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Lookup cache response channel
// Carries the hit flag and value of one request with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface llc_rsp_if import llc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    found;
  logic signed [VAL_W-1:0] value_out;

  modport source (output valid, output found, output value_out, input ready);
  modport sink   (input valid, input found, input value_out, output ready);
endinterface

// ===== design/llc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Lookup cache configuration channel
// Writes the replacement mode register with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface llc_cfg_if ();
  logic valid;
  logic ready;
  logic replace_mode;

  modport source (output valid, output replace_mode, input ready);
  modport sink   (input valid, input replace_mode, output ready);
endinterface

// ===== design/lru_lfu_lookup_cache.sv =====
// ----------------------------------------------------------------------------
// Fully associative lookup cache with LRU or LFU replacement
// A sequencer sweeps the entry store one entry per cycle through a single
// read port and a single write port.
// ----------------------------------------------------------------------------
// A lookup sweeps the entries for its key; a miss then responds, an LRU hit sweeps
// again to update the ranks and an LFU hit writes the raised use count back. An
// insert sweeps for a victim when full, sweeps to update the ranks, moves the last
// entry into the freed slot when it has to, and then writes the new entry.
// A new request is accepted in the idle state, entered as its response is loaded into a free output.
// Reset clears the occupancy and the mode; the entry store is not cleared.
`include "lru_lfu_lookup_cache_macros.svh"

module lru_lfu_lookup_cache import llc_pkg::*; #(
  parameter int ENTRIES = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  llc_cfg_if.sink    cfg_if,
  llc_req_if.sink    req_if,
  llc_rsp_if.source  rsp_if
);

  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [OCC_W-1:0] FULL     = OCC_W'(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  logic [KEY_W-1:0]  key_mem  [ENTRIES];
  logic [VAL_W-1:0]  val_mem  [ENTRIES];
  logic [USES_W-1:0] uses_mem [ENTRIES];
  logic [IDX_W-1:0]  rank_mem [ENTRIES];

  state_e            state_q, state_d;
  logic              mode_q;
  logic [OCC_W-1:0]  occ_q;
  logic [OCC_W-1:0]  iss_q;
  logic              pend_q;
  logic              hit_q;
  logic              out_valid_q;
  logic              lookup_q;

  logic [IDX_W-1:0]  pidx_q;
  logic [KEY_W-1:0]  key_q;
  logic [VAL_W-1:0]  val_q;
  logic [IDX_W-1:0]  best_idx_q;
  logic [IDX_W-1:0]  best_rank_q;
  logic [USES_W-1:0] best_uses_q;
  logic [VAL_W-1:0]  best_val_q;
  logic [KEY_W-1:0]  rd_key_q;
  logic [VAL_W-1:0]  rd_val_q;
  logic [USES_W-1:0] rd_uses_q;
  logic [IDX_W-1:0]  rd_rank_q;
  logic              out_found_q;
  logic [VAL_W-1:0]  out_value_q;

  logic              accept;
  logic              full;
  logic              sweep_state;
  logic              sweep_done;
  logic              out_free;
  logic              lk_match;
  logic              ev_take;

  logic [IDX_W-1:0]  raddr;
  logic [IDX_W-1:0]  waddr;
  logic              we_key, we_val, we_uses, we_rank;
  logic [KEY_W-1:0]  wkey;
  logic [VAL_W-1:0]  wval;
  logic [USES_W-1:0] wuses;
  logic [IDX_W-1:0]  wrank;

  assign cfg_if.ready     = 1'b1;
  assign req_if.ready     = (state_q == S_IDLE);
  assign rsp_if.valid     = out_valid_q;
  assign rsp_if.found     = out_found_q;
  assign rsp_if.value_out = out_value_q;

  assign accept      = req_if.valid && req_if.ready;
  assign full        = (occ_q == FULL);
  assign sweep_state = (state_q == S_SCAN) || (state_q == S_LRU_UPD) ||
                       (state_q == S_EV_SCAN) || (state_q == S_INS_UPD);
  assign sweep_done  = (iss_q == occ_q) && !pend_q;
  assign out_free    = !out_valid_q || rsp_if.ready;

  assign lk_match = pend_q && (rd_key_q == key_q) &&
                    (!hit_q || (rd_rank_q < best_rank_q));

  always_comb begin
    if (mode_q == MODE_LRU) begin
      ev_take = pend_q && (OCC_W'(rd_rank_q) == occ_q - OCC_W'(1));
    end else begin
      ev_take = pend_q && (!hit_q || (rd_uses_q < best_uses_q) ||
                ((rd_uses_q == best_uses_q) && (rd_rank_q < best_rank_q)));
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_if.action == ACT_INSERT) begin
            state_d = full ? S_EV_SCAN : S_INS_UPD;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (sweep_done) begin
          if (!hit_q) begin
            state_d = S_RESP;
          end else if (mode_q == MODE_LFU) begin
            state_d = S_USE_WR;
          end else begin
            state_d = S_LRU_UPD;
          end
        end
      end
      S_LRU_UPD: begin
        if (sweep_done) begin
          state_d = S_RESP;
        end
      end
      S_USE_WR: state_d = S_RESP;
      S_EV_SCAN: begin
        if (sweep_done) begin
          state_d = S_INS_UPD;
        end
      end
      S_INS_UPD: begin
        if (sweep_done) begin
          state_d = (full && (best_idx_q != LAST_IDX)) ? S_COPY_RD : S_NEW_WR;
        end
      end
      S_COPY_RD: state_d = S_COPY_WR;
      S_COPY_WR: state_d = S_NEW_WR;
      S_NEW_WR:  state_d = S_RESP;
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Store port control.
  always_comb begin
    raddr   = (state_q == S_COPY_RD) ? LAST_IDX : iss_q[IDX_W-1:0];
    waddr   = pidx_q;
    we_key  = 1'b0;
    we_val  = 1'b0;
    we_uses = 1'b0;
    we_rank = 1'b0;
    wkey    = rd_key_q;
    wval    = rd_val_q;
    wuses   = rd_uses_q;
    wrank   = rd_rank_q;
    unique case (state_q)
      S_LRU_UPD: begin
        we_rank = pend_q;
        if (pidx_q == best_idx_q) begin
          wrank = '0;
        end else if (rd_rank_q < best_rank_q) begin
          wrank = rd_rank_q + IDX_W'(1);
        end else begin
          wrank = rd_rank_q;
        end
      end
      S_INS_UPD: begin
        we_rank = pend_q;
        if (full && (rd_rank_q > best_rank_q)) begin
          wrank = rd_rank_q;
        end else begin
          wrank = rd_rank_q + IDX_W'(1);
        end
      end
      S_USE_WR: begin
        waddr   = best_idx_q;
        we_uses = 1'b1;
        wuses   = (best_uses_q == USES_MAX) ? best_uses_q : best_uses_q + USES_W'(1);
      end
      S_COPY_WR: begin
        waddr   = best_idx_q;
        we_key  = 1'b1;
        we_val  = 1'b1;
        we_uses = 1'b1;
        we_rank = 1'b1;
      end
      S_NEW_WR: begin
        waddr   = full ? LAST_IDX : occ_q[IDX_W-1:0];
        we_key  = 1'b1;
        we_val  = 1'b1;
        we_uses = 1'b1;
        we_rank = 1'b1;
        wkey    = key_q;
        wval    = val_q;
        wuses   = USES_W'(1);
        wrank   = '0;
      end
      default: begin
        we_rank = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we_key) begin
      key_mem[waddr] <= wkey;
    end
    if (we_val) begin
      val_mem[waddr] <= wval;
    end
    if (we_uses) begin
      uses_mem[waddr] <= wuses;
    end
    if (we_rank) begin
      rank_mem[waddr] <= wrank;
    end
    rd_key_q  <= key_mem[raddr];
    rd_val_q  <= val_mem[raddr];
    rd_uses_q <= uses_mem[raddr];
    rd_rank_q <= rank_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_LRU;
      occ_q       <= '0;
      iss_q       <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_if.valid) begin
        mode_q <= cfg_if.replace_mode;
      end
      if (state_d != state_q) begin
        iss_q  <= '0;
        pend_q <= 1'b0;
      end else if (sweep_state) begin
        pend_q <= (iss_q < occ_q);
        if (iss_q < occ_q) begin
          iss_q <= iss_q + OCC_W'(1);
        end
      end
      if (accept) begin
        hit_q <= 1'b0;
      end else if ((state_q == S_SCAN && lk_match) || (state_q == S_EV_SCAN && ev_take)) begin
        hit_q <= 1'b1;
      end
      if (state_q == S_NEW_WR && !full) begin
        occ_q <= occ_q + OCC_W'(1);
      end
      if (state_q == S_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= iss_q[IDX_W-1:0];
    if (accept) begin
      key_q <= req_if.key;
      val_q <= req_if.value_in;
    end
    if ((state_q == S_SCAN && lk_match) || (state_q == S_EV_SCAN && ev_take)) begin
      best_idx_q  <= pidx_q;
      best_rank_q <= rd_rank_q;
      best_uses_q <= rd_uses_q;
      best_val_q  <= rd_val_q;
    end
    if (state_q == S_RESP && out_free) begin
      out_found_q <= hit_q && lookup_q;
      out_value_q <= (hit_q && lookup_q) ? best_val_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lookup_q <= (req_if.action == ACT_LOOKUP);
    end
  end

  `LLC_ASSERT(a_occ_bound, occ_q <= FULL, "occupancy above the entry count")
  `LLC_ASSERT(a_sweep_bound, iss_q <= occ_q, "sweep counter passed the occupancy")
  `LLC_ASSERT(a_occ_step,
    (occ_q != $past(occ_q)) |->
      ($past(state_q) == S_NEW_WR) && (occ_q == $past(occ_q) + OCC_W'(1)),
    "occupancy changed outside an insert write")
  `LLC_ASSERT(a_rsp_src, $rose(out_valid_q) |-> ($past(state_q) == S_RESP),
    "response raised outside the response state")
  `LLC_ASSERT_ALWAYS(a_rst_idle, !rst_ni |=> (state_q == S_IDLE) || rst_ni,
    "sequencer not idle after reset")

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Lookup cache testbench
// Drives lookup and insert requests into the cache under both replacement
// modes, with bursty requests, an uneven response stall pattern and one long
// response hold-off. A scoreboard keeps its own copy of the entries and checks
// every response in order against it.
// ----------------------------------------------------------------------------
module testbench;
  import llc_pkg::*;

  localparam int          ENTRIES       = 8;
  localparam int          SETTLE_CYCLES = 2 * ENTRIES + 12;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          POOL_SIZE     = 12;
  localparam int          RAND_PHASES   = 6;
  localparam int          PHASE_ITEMS   = 160;
  localparam int unsigned LIMIT_CYCLES  = 3_000_000;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] value;
  } answer_t;

  class cache_scoreboard;
    logic [KEY_W-1:0]  entry_key  [ENTRIES];
    logic [VAL_W-1:0]  entry_val  [ENTRIES];
    logic [USES_W-1:0] entry_uses [ENTRIES];
    int                entry_rank [ENTRIES];
    int                fill;
    mode_e             mode;
    answer_t           answers [$];
    int errors, lookups, hits, inserts, lru_evicts, lfu_evicts;

    function new();
      fill = 0;
      mode = MODE_LRU;
    endfunction

    function void set_mode(mode_e m);
      mode = m;
    endfunction

    function int pending();
      return answers.size();
    endfunction

    function void evict_entry();
      int victim;
      int vr;
      victim = 0;
      if (mode == MODE_LRU) begin
        for (int i = 0; i < fill; i++)
          if (entry_rank[i] == fill - 1) victim = i;
        lru_evicts++;
      end else begin
        for (int i = 1; i < fill; i++)
          if (entry_uses[i] < entry_uses[victim] ||
              (entry_uses[i] == entry_uses[victim] &&
               entry_rank[i] < entry_rank[victim])) victim = i;
        lfu_evicts++;
      end
      vr = entry_rank[victim];
      for (int i = 0; i < fill; i++)
        if (entry_rank[i] > vr) entry_rank[i]--;
      if (victim != fill - 1) begin
        entry_key[victim]  = entry_key[fill-1];
        entry_val[victim]  = entry_val[fill-1];
        entry_uses[victim] = entry_uses[fill-1];
        entry_rank[victim] = entry_rank[fill-1];
      end
      fill--;
    endfunction

    function void note_request(action_e act, logic [KEY_W-1:0] key,
                               logic [VAL_W-1:0] value);
      answer_t ans;
      int      best;
      bit      hit;
      ans  = '0;
      hit  = 1'b0;
      best = 0;
      if (act == ACT_LOOKUP) begin
        lookups++;
        for (int i = 0; i < fill; i++)
          if (entry_key[i] == key && (!hit || entry_rank[i] < entry_rank[best])) begin
            hit  = 1'b1;
            best = i;
          end
        if (hit) begin
          hits++;
          ans.found = 1'b1;
          ans.value = entry_val[best];
          if (mode == MODE_LRU) begin
            for (int i = 0; i < fill; i++)
              if (entry_rank[i] < entry_rank[best]) entry_rank[i]++;
            entry_rank[best] = 0;
          end else if (entry_uses[best] != USES_MAX) begin
            entry_uses[best]++;
          end
        end
      end else begin
        inserts++;
        if (fill >= ENTRIES) evict_entry();
        for (int i = 0; i < fill; i++) entry_rank[i]++;
        entry_key[fill]  = key;
        entry_val[fill]  = value;
        entry_uses[fill] = 1;
        entry_rank[fill] = 0;
        fill++;
      end
      answers.push_back(ans);
    endfunction

    function void check_response(logic found, logic [VAL_W-1:0] value);
      answer_t want;
      if (answers.size() == 0) begin
        errors++;
        $display("%0t: unexpected response, found %b value %0d", $time, found,
                 $signed(value));
        return;
      end
      want = answers.pop_front();
      if (found !== want.found) begin
        errors++;
        $display("%0t: found mismatch, expected %b actual %b", $time, want.found, found);
      end
      if (value !== want.value) begin
        errors++;
        $display("%0t: value_out mismatch, expected %0d actual %0d", $time,
                 $signed(want.value), $signed(value));
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   hold_response;

  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  cache_scoreboard  sb = new();

  llc_cfg_if cfg ();
  llc_req_if req ();
  llc_rsp_if rsp ();

  lru_lfu_lookup_cache #(
    .ENTRIES(ENTRIES)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_if(cfg),
    .req_if(req),
    .rsp_if(rsp)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp.valid && rsp.ready) sb.check_response(rsp.found, rsp.value_out);
  end

  initial begin : rsp_stall
    int seg_len;
    int pattern;
    int period;
    rsp.ready <= 1'b0;
    forever begin
      pattern = $urandom_range(0, 3);
      seg_len = $urandom_range(10, 150);
      period  = $urandom_range(2, 5);
      for (int ph = 0; ph < seg_len; ph++) begin
        @(posedge clk_i);
        if (hold_response) begin
          rsp.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk_i);
          hold_response = 1'b0;
        end
        case (pattern)
          0: rsp.ready <= 1'b1;
          1: rsp.ready <= $urandom_range(0, 1);
          2: rsp.ready <= ($urandom_range(0, 3) == 0);
          default: rsp.ready <= (ph % period == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_req(action_e act, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
    req.valid    <= 1'b1;
    req.action   <= act;
    req.key      <= key;
    req.value_in <= value;
    do @(posedge clk_i); while (!req.ready);
    sb.note_request(act, key, value);
  endtask

  task automatic idle_req(int cycles);
    req.valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mode(mode_e m);
    drain();
    cfg.valid        <= 1'b1;
    cfg.replace_mode <= m;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    sb.set_mode(m);
  endtask

  task automatic run_random(int count);
    action_e          act;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    int               burst_left;
    burst_left = 0;
    foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom);
    for (int n = 0; n < count; n++) begin
      if (burst_left == 0) begin
        idle_req($urandom_range(1, 12));
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      act = ($urandom_range(0, 99) < 38) ? ACT_INSERT : ACT_LOOKUP;
      if ($urandom_range(0, 99) < 80) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else key = KEY_W'($urandom);
      case ($urandom_range(0, 19))
        0: value = 32'h8000_0000;
        1: value = 32'h7fff_ffff;
        2: value = '0;
        3: value = '1;
        default: value = $urandom;
      endcase
      send_req(act, key, value);
    end
  endtask

  initial begin : stimulus
    mode_e next_mode;
    req.valid        <= 1'b0;
    req.action       <= ACT_LOOKUP;
    req.key          <= '0;
    req.value_in     <= '0;
    cfg.valid        <= 1'b0;
    cfg.replace_mode <= MODE_LRU;
    rst_ni           <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_mode(MODE_LRU);
    send_req(ACT_LOOKUP, 16'h0000, '0);
    send_req(ACT_INSERT, 16'h0000, 32'h8000_0000);
    send_req(ACT_INSERT, 16'hffff, 32'h7fff_ffff);
    send_req(ACT_LOOKUP, 16'h0000, '1);
    send_req(ACT_LOOKUP, 16'hffff, '0);
    send_req(ACT_LOOKUP, 16'h1234, $urandom);
    send_req(ACT_INSERT, 16'h0000, 32'd5);
    send_req(ACT_LOOKUP, 16'h0000, '0);
    send_req(ACT_LOOKUP, 16'hffff, '0);
    send_req(ACT_INSERT, 16'h00a5, 32'hffff_ffff);
    send_req(ACT_INSERT, 16'h5a00, '0);
    send_req(ACT_LOOKUP, 16'h0000, '0);
    send_req(ACT_INSERT, 16'h8001, $urandom);
    send_req(ACT_INSERT, 16'h7ffe, $urandom);
    send_req(ACT_INSERT, 16'h0f0f, $urandom);
    send_req(ACT_INSERT, 16'hc3c3, $urandom);
    send_req(ACT_LOOKUP, 16'hffff, '0);
    send_req(ACT_LOOKUP, 16'h00a5, '0);

    write_mode(MODE_LFU);
    send_req(ACT_LOOKUP, 16'h0f0f, '0);
    send_req(ACT_LOOKUP, 16'h0f0f, '0);
    send_req(ACT_LOOKUP, 16'h0f0f, '0);
    send_req(ACT_LOOKUP, 16'hc3c3, '0);
    send_req(ACT_LOOKUP, 16'hc3c3, '0);
    send_req(ACT_LOOKUP, 16'h0000, '0);
    send_req(ACT_INSERT, 16'h1111, $urandom);
    send_req(ACT_INSERT, 16'h2222, $urandom);
    send_req(ACT_LOOKUP, 16'h1111, '0);
    send_req(ACT_LOOKUP, 16'h2222, '0);
    send_req(ACT_INSERT, 16'h3333, $urandom);

    next_mode = MODE_LRU;
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      write_mode(next_mode);
      next_mode = (next_mode == MODE_LRU) ? MODE_LFU : MODE_LRU;
      if (phase == 1) hold_response = 1'b1;
      run_random(PHASE_ITEMS);
    end
    drain();

    $display("Covered %0d requests: %0d lookups with %0d hits, %0d inserts.",
             sb.lookups + sb.inserts, sb.lookups, sb.hits, sb.inserts);
    $display("Evictions: %0d by recency, %0d by use count.",
             sb.lru_evicts, sb.lfu_evicts);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ===== lru_lfu_lookup_cache.f =====
+incdir+design
design/llc_pkg.sv
design/llc_req_if.sv
design/llc_rsp_if.sv
design/llc_cfg_if.sv
design/lru_lfu_lookup_cache.sv
tb/testbench.sv
